@@ design/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-step composition counter package
// Shared widths, the modulus and the table command type.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int FIELD_W   = 13;
    localparam int COUNT_W   = 30;
    localparam int FIELD_MAX = 8191;

    localparam logic [COUNT_W-1:0] WAY_MOD = 30'd1000000007;
    localparam logic [COUNT_W-1:0] WAY_ONE = 30'd1;

    typedef struct packed {
        logic               wr_en;
        logic [FIELD_W-1:0] wr_addr;
        logic [COUNT_W-1:0] wr_data;
        logic [FIELD_W-1:0] rd_addr_a;
        logic [FIELD_W-1:0] rd_addr_b;
    } tsc_tbl_cmd_t;

endpackage

`default_nettype wire

@@ design/tsc_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the length range and the two block lengths.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_req_if import tsc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
    logic [FIELD_W-1:0] first_step;
    logic [FIELD_W-1:0] second_step;

    modport source (
        output valid,
        output range_low,
        output range_high,
        output first_step,
        output second_step,
        input  ready
    );

    modport sink (
        input  valid,
        input  range_low,
        input  range_high,
        input  first_step,
        input  second_step,
        output ready
    );

endinterface

`default_nettype wire

@@ design/tsc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the count and the rejection flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_rsp_if import tsc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] way_count;
    logic               bad_request;

    modport source (
        output valid,
        output way_count,
        output bad_request,
        input  ready
    );

    modport sink (
        input  valid,
        input  way_count,
        input  bad_request,
        output ready
    );

endinterface

`default_nettype wire

@@ design/tsc_addmod.sv @@
// ----------------------------------------------------------------------------
// Modular adder
// Adds two residues below the modulus and folds the sum back into range.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_addmod
    import tsc_pkg::*;
(
    input  wire logic [COUNT_W-1:0] op_x,
    input  wire logic [COUNT_W-1:0] op_y,
    output logic      [COUNT_W-1:0] sum
);

    logic [COUNT_W:0] raw;

    assign raw = {1'b0, op_x} + {1'b0, op_y};

    always_comb
    begin
        if (raw >= {1'b0, WAY_MOD})
        begin
            sum = COUNT_W'(raw - {1'b0, WAY_MOD});
        end
        else
        begin
            sum = raw[COUNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/tsc_table.sv @@
// ----------------------------------------------------------------------------
// Ways table
// One write port and two registered read ports over the per-length counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_table
    import tsc_pkg::*;
#(
    parameter int DEPTH = 4097
)
(
    input  wire logic               clk,
    input  wire tsc_tbl_cmd_t       cmd,
    output logic      [COUNT_W-1:0] rd_data_a,
    output logic      [COUNT_W-1:0] rd_data_b
);

    localparam int AW = $clog2(DEPTH);

    logic [COUNT_W-1:0] ways_mem [DEPTH];
    logic [COUNT_W-1:0] rd_a_reg;
    logic [COUNT_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ways_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        rd_a_reg <= ways_mem[cmd.rd_addr_a[AW-1:0]];
        rd_b_reg <= ways_mem[cmd.rd_addr_b[AW-1:0]];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

@@ design/two_step_composition_counter.sv @@
// ----------------------------------------------------------------------------
// Two-step composition counter
// Fills the ways table per length and sums the ways in the range, mod prime.
// ----------------------------------------------------------------------------
// A request passes S_INIT, then S_READ and S_SUM for each table entry on the
// shared modular adder and the table's read ports, then S_FLUSH and S_DONE;
// with range_high zero S_INIT goes straight to S_DONE, and a rejected request
// goes from S_IDLE to S_DONE. A new request is taken only in S_IDLE, after the
// last result is in the output register. Reset clears all control state; the
// table needs no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module two_step_composition_counter
    import tsc_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tsc_req_if.sink   req,
    tsc_rsp_if.source rsp
);

    localparam int DEPTH = ((MAX_LEN < FIELD_MAX) ? MAX_LEN : FIELD_MAX) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_READ  = 6'b000100,
        S_SUM   = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [FIELD_W-1:0] n_reg, n_next;
    logic [FIELD_W-1:0] lo_reg, lo_next;
    logic [FIELD_W-1:0] hi_reg, hi_next;
    logic [FIELD_W-1:0] a_reg, a_next;
    logic [FIELD_W-1:0] b_reg, b_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] v_reg, v_next;
    logic               use_a_reg, use_a_next;
    logic               use_b_reg, use_b_next;
    logic               acc_reg, acc_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_bad_reg, out_bad_next;

    tsc_tbl_cmd_t       cmd;
    logic [COUNT_W-1:0] rd_data_a;
    logic [COUNT_W-1:0] rd_data_b;
    logic [COUNT_W-1:0] op_x;
    logic [COUNT_W-1:0] op_y;
    logic [COUNT_W-1:0] sum;
    logic               req_bad;

    tsc_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk       (clk),
        .cmd       (cmd),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    tsc_addmod u_addmod (
        .op_x (op_x),
        .op_y (op_y),
        .sum  (sum)
    );

    assign req_bad = (32'(req.range_high) > 32'(MAX_LEN))
                     || (req.first_step == '0) || (req.second_step == '0);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.way_count   = out_count_reg;
    assign rsp.bad_request = out_bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        total_next     = total_reg;
        v_next         = v_reg;
        use_a_next     = use_a_reg;
        use_b_next     = use_b_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_count_next = out_count_reg;
        out_bad_next   = out_bad_reg;

        cmd            = '0;
        op_x           = total_reg;
        op_y           = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    lo_next    = req.range_low;
                    hi_next    = req.range_high;
                    a_next     = req.first_step;
                    b_next     = req.second_step;
                    total_next = '0;
                    bad_next   = req_bad;
                    state_next = req_bad ? S_DONE : S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = '0;
                cmd.wr_data = WAY_ONE;
                n_next      = FIELD_W'(1);
                acc_next    = 1'b0;
                state_next  = (hi_reg == '0) ? S_DONE : S_READ;
            end
            S_READ:
            begin
                use_a_next = (n_reg >= a_reg);
                use_b_next = (n_reg >= b_reg);
                if (n_reg >= a_reg)
                begin
                    cmd.rd_addr_a = n_reg - a_reg;
                end
                if (n_reg >= b_reg)
                begin
                    cmd.rd_addr_b = n_reg - b_reg;
                end
                if (acc_reg)
                begin
                    total_next = sum;
                end
                acc_next   = 1'b0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                op_x        = use_a_reg ? rd_data_a : '0;
                op_y        = use_b_reg ? rd_data_b : '0;
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = n_reg;
                cmd.wr_data = sum;
                v_next      = sum;
                acc_next    = (n_reg >= lo_reg);
                if (n_reg == hi_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    n_next     = n_reg + FIELD_W'(1);
                    state_next = S_READ;
                end
            end
            S_FLUSH:
            begin
                if (acc_reg)
                begin
                    total_next = sum;
                end
                acc_next   = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = total_reg;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            total_reg     <= '0;
            v_reg         <= '0;
            use_a_reg     <= 1'b0;
            use_b_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            total_reg     <= total_next;
            v_reg         <= v_next;
            use_a_reg     <= use_a_next;
            use_b_reg     <= use_b_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_bad_reg   <= out_bad_next;
        end
    end

endmodule

`default_nettype wire
